// ===== rtl/tsfe_pkg.sv =====
package tsfe_pkg;

    localparam int MAX_ENTRIES = 255;

    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 8;
    localparam int FILL_W  = 8;
    localparam int CMD_W   = 2;
    localparam int PADDR_W = 3;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE_EXP = 2'd2;

    localparam logic REG_LIMIT  = 1'b0;
    localparam logic REG_EXPIRY = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd255;
    localparam logic [DATA_W-1:0]  EXPIRY_RESET = 32'd0;

endpackage

// ===== rtl/tsfe_ram.sv =====
module tsfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/timestamped_fifo_with_expiry.sv =====
// channel   ports                                   transaction
// --------  --------------------------------------  --------------------------------------
// command   i_start, o_busy, i_command,             accepted when i_start high, o_busy low
//           i_entry_value, i_now_tick               and no config write in that cycle
// result    o_done, o_success, o_popped_value,      one cycle wide, marked by o_done
//           o_popped_stamp, o_fill_count
// config    psel, penable, pwrite, paddr,           write on access cycle, pready tied high
//           pwdata, prdata, pready
//
// one command per cycle; its result shows in the cycle after it is accepted
// the head slot is prefetched through the storage ram's registered read port,
// with a bypass for an enqueue into an empty queue
// o_busy stays low, the result side cannot stall
// synchronous active-low reset: empty queue, limit 255, expiry 0; no clearing pass
module timestamped_fifo_with_expiry #(
    parameter int MAX_ENTRIES = tsfe_pkg::MAX_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [tsfe_pkg::CMD_W-1:0]        i_command,
    input  logic [tsfe_pkg::DATA_W-1:0]       i_entry_value,
    input  logic [tsfe_pkg::DATA_W-1:0]       i_now_tick,
    output logic                              o_done,
    output logic                              o_success,
    output logic [tsfe_pkg::DATA_W-1:0]       o_popped_value,
    output logic [tsfe_pkg::DATA_W-1:0]       o_popped_stamp,
    output logic [tsfe_pkg::FILL_W-1:0]       o_fill_count,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsfe_pkg::PADDR_W-1:0]      paddr,
    input  logic [tsfe_pkg::DATA_W-1:0]       pwdata,
    output logic [tsfe_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int DEPTH = MAX_ENTRIES + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = ((IDX_W > tsfe_pkg::LIMIT_W) ? IDX_W : tsfe_pkg::LIMIT_W) + 1;
    localparam int DW    = tsfe_pkg::DATA_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    logic [tsfe_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic [DW-1:0]                r_expiry, n_expiry;
    logic [IDX_W-1:0]             r_rd, n_rd;
    logic [IDX_W-1:0]             r_wr, n_wr;
    logic                         r_fwd, n_fwd;
    logic [2*DW-1:0]              r_fwd_data;
    logic                         r_done, n_done;
    logic                         r_success, n_success;
    logic [DW-1:0]                r_pv, n_pv;
    logic [DW-1:0]                r_ps, n_ps;
    logic [tsfe_pkg::FILL_W-1:0]  r_fill, n_fill;

    logic            accept;
    logic            cfg_we;
    logic            ram_we;
    logic [2*DW-1:0] ram_wdata;
    logic [2*DW-1:0] ram_rdata;
    logic [2*DW-1:0] head;
    logic [CW-1:0]   eff;
    logic [CW-1:0]   fill_now;
    logic [CW-1:0]   fill_after;
    logic [CW-1:0]   rd_inc;
    logic [CW-1:0]   wr_inc;
    logic [DW:0]     due;
    logic            expired;

    function automatic logic [CW-1:0] fill_of(
        input logic [IDX_W-1:0] w,
        input logic [IDX_W-1:0] r,
        input logic [CW-1:0]    e
    );
        logic [CW-1:0] we;
        logic [CW-1:0] re;
        we = CW'(w);
        re = CW'(r);
        if (we >= re) begin
            return we - re;
        end
        return we + e + CW'(1) - re;
    endfunction

    assign accept = i_start & ~o_busy;
    assign cfg_we = psel & penable & pwrite & pready;

    assign eff      = (CW'(r_limit) > MAX_C) ? MAX_C : CW'(r_limit);
    assign fill_now = fill_of(r_wr, r_rd, eff);
    assign rd_inc   = CW'(r_rd) + CW'(1);
    assign wr_inc   = CW'(r_wr) + CW'(1);

    assign head    = r_fwd ? r_fwd_data : ram_rdata;
    assign due     = {1'b0, head[DW-1:0]} + {1'b0, r_expiry};
    assign expired = due <= {1'b0, i_now_tick};

    assign ram_wdata = {i_entry_value, i_now_tick};

    always_comb begin
        n_limit   = r_limit;
        n_expiry  = r_expiry;
        n_rd      = r_rd;
        n_wr      = r_wr;
        ram_we    = 1'b0;
        n_success = 1'b0;
        n_pv      = '0;
        n_ps      = '0;
        if (cfg_we) begin
            case (paddr[2])
                tsfe_pkg::REG_LIMIT: begin
                    n_limit = pwdata[tsfe_pkg::LIMIT_W-1:0];
                    n_rd    = '0;
                    n_wr    = '0;
                end
                tsfe_pkg::REG_EXPIRY: begin
                    n_expiry = pwdata;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            case (i_command)
                tsfe_pkg::CMD_ENQUEUE: begin
                    if (fill_now < eff) begin
                        ram_we    = 1'b1;
                        n_wr      = (wr_inc > eff) ? '0 : wr_inc[IDX_W-1:0];
                        n_success = 1'b1;
                    end
                end
                tsfe_pkg::CMD_DEQUEUE, tsfe_pkg::CMD_DEQUEUE_EXP: begin
                    if (fill_now != '0 &&
                        (i_command == tsfe_pkg::CMD_DEQUEUE || expired)) begin
                        n_rd      = (rd_inc > eff) ? '0 : rd_inc[IDX_W-1:0];
                        n_success = 1'b1;
                        n_pv      = head[2*DW-1:DW];
                        n_ps      = head[DW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign fill_after = fill_of(n_wr, n_rd, eff);
    assign n_fill     = fill_after[tsfe_pkg::FILL_W-1:0];
    assign n_done     = accept & ~cfg_we;
    assign n_fwd      = ram_we & (r_wr == n_rd);

    tsfe_ram #(
        .WIDTH (2 * DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr),
        .i_wdata (ram_wdata),
        .i_raddr (n_rd),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= tsfe_pkg::LIMIT_RESET;
            r_expiry <= tsfe_pkg::EXPIRY_RESET;
            r_rd     <= '0;
            r_wr     <= '0;
            r_fwd    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_limit  <= n_limit;
            r_expiry <= n_expiry;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_fwd    <= n_fwd;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
        r_success  <= n_success;
        r_pv       <= n_pv;
        r_ps       <= n_ps;
        r_fill     <= n_fill;
    end

    always_comb begin
        case (paddr[2])
            tsfe_pkg::REG_LIMIT:  prdata = DW'(r_limit);
            tsfe_pkg::REG_EXPIRY: prdata = r_expiry;
            default:              prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_busy         = 1'b0;
    assign o_done         = r_done;
    assign o_success      = r_success;
    assign o_popped_value = r_pv;
    assign o_popped_stamp = r_ps;
    assign o_fill_count   = r_fill;

endmodule
